### sv/lzss_pkg.sv
// Shared types and fixed constants for the LZSS stream decoder.
// No dependencies; imported by lzss_dict and lzss_stream_decoder.
package lzss_pkg;

  localparam int BYTE_W    = 8;   // width of a compressed or decompressed byte
  localparam int NBITS_W   = 4;   // holds a count of 0..8 unread bits in a byte
  localparam int COPY_BIAS = 3;   // a match copies length + 3 bytes

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

### sv/lzss_stream_decoder.sv
// LZSS stream decoder top level: bit parser, copy engine, output stage.
// Depends on lzss_pkg and lzss_dict.
//
// - Slave channel s_axis takes one compressed byte per item. tuser[0] starts a
//   new stream (write position 1, parser at a flag bit); tlast marks the last
//   compressed byte, after which zero bits are fed until the end marker.
// - Master channel m_axis gives decompressed bytes, one per item. tuser[0] is
//   set on data bytes, tuser[1] on the end-of-stream item; tlast marks the last
//   item caused by one input item. An input item may cause no output at all.
// - Throughput: one input item at a time. The parser takes a flag bit or as many
//   bits of a field as the byte, or the zero fill after a final byte, holds per
//   cycle; a match copies one byte per cycle. Both stall while a held result must
//   move on to a stalled receiver. Once the item is parsed, the last held result
//   is handed over as the last item.
// - Output: each result is held until the next one, or the end of the item, tells
//   whether it is last; it then moves to the output register that drives m_axis.
// - Reset: a clearing pass zeroes the dictionary (DICT_DEPTH entries, a power of
//   two), one entry per cycle; s_axis_tready stays low meanwhile.
// - A stalled receiver holds the output register; the decoder waits with it and
//   loses nothing. The next input item is taken while a result still waits.
module lzss_stream_decoder
  import lzss_pkg::*;
#(
  parameter int OFFSET_BITS = 13,
  parameter int LENGTH_BITS = 4,
  parameter int DICT_DEPTH  = 8192
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic [0:0] s_axis_tuser,   // [0] first_byte
  input  logic       s_axis_tlast,   // final_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] stream_end
  output logic       m_axis_tlast    // last_of_run
);

  localparam int ADDR_W = $clog2(DICT_DEPTH);
  localparam int ACC_W  = OFFSET_BITS;
  localparam int BL_W   = $clog2(OFFSET_BITS + 1);
  localparam int CNT_W  = LENGTH_BITS + 1;
  // data bytes reported per input item; the end item always fits after them
  localparam logic [CNT_W-1:0] DATA_LIMIT = CNT_W'((1 << LENGTH_BITS) + 2);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PARSE = 4'b0100,
    S_COPY  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_LIT  = 2'd1,
    PH_POS  = 2'd2,
    PH_LEN  = 2'd3
  } phase_t;

  state_t              state, state_next;
  phase_t              phase, phase_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic [ADDR_W-1:0]   wp, wp_next;
  logic [ADDR_W-1:0]   cp, cp_next;
  logic [BL_W-1:0]     bits_left, bits_left_next;
  logic [ACC_W-1:0]    acc, acc_next;
  logic                ended, ended_next;
  byte_t               sh, sh_next;
  logic [NBITS_W-1:0]  nbits, nbits_next;
  logic                last_byte, last_byte_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [CNT_W-1:0]    rem, rem_next;

  // one-result hold stage: tlast is known only when the next result or item end comes
  logic                pend_valid, pend_valid_next;
  byte_t               pend_byte, pend_byte_next;
  logic                pend_bv, pend_bv_next;
  logic                pend_end, pend_end_next;

  logic                out_valid;
  byte_t               out_byte;
  logic                out_bv, out_end, out_last;
  logic                push, push_last, push_ok;

  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  byte_t               wdata, rdata;

  // parser datapath
  logic [BL_W-1:0]     avail, take, bl_after;
  byte_t               chunk;
  logic [ACC_W-1:0]    acc_shift;
  logic                done, flag_bit, fin, fill;
  logic                lit_done, end_done, pos_done, len_done, emit_new, emit_c;

  lzss_dict #(
    .ADDR_W (ADDR_W)
  ) u_dict (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  assign push_ok       = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  // zero fill runs once a final byte has given up all its bits
  assign fill = last_byte && (nbits == '0);

  // take as many bits of the current field as the byte (or the zero fill) holds
  always_comb begin
    avail     = fill ? bits_left : BL_W'(nbits);
    take      = (bits_left < avail) ? bits_left : avail;
    bl_after  = bits_left - take;
    chunk     = fill ? '0 : byte_t'(sh >> (BL_W'(BYTE_W) - take));
    acc_shift = (acc << take) | ACC_W'(chunk);
    flag_bit  = fill ? 1'b0 : sh[BYTE_W-1];
    done      = ended || ((nbits == '0) && !fill);
    fin       = (bl_after == '0);
    lit_done  = fin && (phase == PH_LIT);
    end_done  = fin && (phase == PH_POS) && (acc_shift == '0);
    pos_done  = fin && (phase == PH_POS) && (acc_shift != '0);
    len_done  = fin && (phase == PH_LEN);
    emit_new  = (lit_done && (cnt < DATA_LIMIT)) || end_done;
    emit_c    = (cnt < DATA_LIMIT);
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    clr_addr_next   = clr_addr;
    wp_next         = wp;
    cp_next         = cp;
    bits_left_next  = bits_left;
    acc_next        = acc;
    ended_next      = ended;
    sh_next         = sh;
    nbits_next      = nbits;
    last_byte_next  = last_byte;
    cnt_next        = cnt;
    rem_next        = rem;
    pend_valid_next = pend_valid;
    pend_byte_next  = pend_byte;
    pend_bv_next    = pend_bv;
    pend_end_next   = pend_end;
    push            = 1'b0;
    push_last       = 1'b0;
    we              = 1'b0;
    waddr           = wp;
    wdata           = '0;
    raddr           = cp;

    unique case (state)
      S_CLEAR: begin
        we            = 1'b1;
        waddr         = clr_addr;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          sh_next        = s_axis_tdata;
          nbits_next     = NBITS_W'(BYTE_W);
          last_byte_next = s_axis_tlast;
          cnt_next       = '0;
          if (s_axis_tuser[0]) begin
            wp_next        = ADDR_W'(1);
            phase_next     = PH_FLAG;
            bits_left_next = '0;
            acc_next       = '0;
            ended_next     = 1'b0;
          end
          state_next = S_PARSE;
        end
      end

      S_PARSE: begin
        if (done) begin
          // item finished: hand over the held result as the last one
          if (pend_valid) begin
            if (push_ok) begin
              push            = 1'b1;
              push_last       = 1'b1;
              pend_valid_next = 1'b0;
              state_next      = S_IDLE;
            end
          end else begin
            state_next = S_IDLE;
          end
        end else if (phase == PH_FLAG) begin
          if (!fill) begin
            sh_next    = sh << 1;
            nbits_next = nbits - NBITS_W'(1);
          end
          phase_next     = flag_bit ? PH_LIT : PH_POS;
          bits_left_next = flag_bit ? BL_W'(BYTE_W) : BL_W'(OFFSET_BITS);
          acc_next       = '0;
        end else if (!(emit_new && pend_valid && !push_ok)) begin
          if (!fill) begin
            sh_next    = sh << take;
            nbits_next = nbits - NBITS_W'(take);
          end
          acc_next       = acc_shift;
          bits_left_next = bl_after;
          if (emit_new) begin
            push            = pend_valid;
            pend_valid_next = 1'b1;
            pend_byte_next  = lit_done ? acc_shift[BYTE_W-1:0] : '0;
            pend_bv_next    = lit_done;
            pend_end_next   = end_done;
          end
          if (lit_done) begin
            we         = 1'b1;
            wdata      = acc_shift[BYTE_W-1:0];
            wp_next    = wp + ADDR_W'(1);
            if (emit_new) begin
              cnt_next = cnt + CNT_W'(1);
            end
            phase_next = PH_FLAG;
            acc_next   = '0;
          end
          if (end_done) begin
            ended_next = 1'b1;
            phase_next = PH_FLAG;
            acc_next   = '0;
          end
          if (pos_done) begin
            cp_next        = ADDR_W'(acc_shift);
            phase_next     = PH_LEN;
            bits_left_next = BL_W'(LENGTH_BITS);
            acc_next       = '0;
          end
          if (len_done) begin
            rem_next   = CNT_W'(acc_shift[LENGTH_BITS-1:0]) + CNT_W'(COPY_BIAS);
            raddr      = cp;
            phase_next = PH_FLAG;
            acc_next   = '0;
            state_next = S_COPY;
          end
        end
      end

      S_COPY: begin
        // rdata holds the byte at cp; stall only when a result must move on
        if (!(emit_c && pend_valid && !push_ok)) begin
          we      = 1'b1;
          wdata   = rdata;
          wp_next = wp + ADDR_W'(1);
          cp_next = cp + ADDR_W'(1);
          raddr   = cp + ADDR_W'(1);
          rem_next = rem - CNT_W'(1);
          if (emit_c) begin
            push            = pend_valid;
            pend_valid_next = 1'b1;
            pend_byte_next  = rdata;
            pend_bv_next    = 1'b1;
            pend_end_next   = 1'b0;
            cnt_next        = cnt + CNT_W'(1);
          end
          if (rem == CNT_W'(1)) begin
            state_next = S_PARSE;
          end
        end else begin
          raddr = cp;
        end
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      phase      <= PH_FLAG;
      clr_addr   <= '0;
      wp         <= ADDR_W'(1);
      cp         <= '0;
      bits_left  <= '0;
      acc        <= '0;
      ended      <= 1'b0;
      nbits      <= '0;
      last_byte  <= 1'b0;
      cnt        <= '0;
      rem        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      clr_addr   <= clr_addr_next;
      wp         <= wp_next;
      cp         <= cp_next;
      bits_left  <= bits_left_next;
      acc        <= acc_next;
      ended      <= ended_next;
      nbits      <= nbits_next;
      last_byte  <= last_byte_next;
      cnt        <= cnt_next;
      rem        <= rem_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sh        <= sh_next;
    pend_byte <= pend_byte_next;
    pend_bv   <= pend_bv_next;
    pend_end  <= pend_end_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_byte <= pend_byte;
      out_bv   <= pend_bv;
      out_end  <= pend_end;
      out_last <= push_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tuser  = {out_end, out_bv};
  assign m_axis_tlast  = out_last;

endmodule

### sv/lzss_dict.sv
// Dictionary memory: one write port, one registered read port.
// A read of the entry written in the same cycle returns the new data.
// Depends on lzss_pkg.
module lzss_dict
  import lzss_pkg::*;
#(
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  byte_t             wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output byte_t             rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  byte_t mem [DEPTH];
  byte_t rd_q;
  byte_t fwd_q;
  logic  fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q    <= mem[rd_addr];
    fwd_hit <= wr_en && (wr_addr == rd_addr);
    fwd_q   <= wr_data;
  end

  // same-cycle write wins over the old memory contents
  assign rd_data = fwd_hit ? fwd_q : rd_q;

endmodule

### tb/sv/tb_lzss_stream_decoder.sv
// Self-checking testbench for lzss_stream_decoder: compressed streams in, decoded bytes out.
// Depends on lzss_pkg and the decoder RTL; an in-bench decoder model predicts every output item.
module tb_lzss_stream_decoder
  import lzss_pkg::*;
();

  localparam int POS_W       = 13;
  localparam int LEN_W       = 4;
  localparam int DEPTH       = 8192;
  localparam int MAX_OUT     = (1 << LEN_W) + COPY_BIAS;  // 18 data bytes + end item
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 24;

  typedef enum logic [1:0] {PH_FLAG, PH_LITERAL, PH_POSITION, PH_LENGTH} parse_phase_t;
  typedef enum logic [1:0] {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_t;

  typedef struct {
    byte_t data;
    bit    first;
    bit    final_in;
  } in_item_t;

  typedef struct {
    byte_t data;
    bit    valid;
    bit    last;
    bit    done;
  } out_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] in_byte
  logic [0:0] s_axis_tuser = '0;   // [0] first_byte
  logic       s_axis_tlast = 1'b0; // final_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] out_byte
  logic [1:0] m_axis_tuser;        // [0] byte_valid, [1] stream_end
  logic       m_axis_tlast;        // last_of_run

  lzss_stream_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model: own dictionary, write pointer and bit parser
  // ---------------------------------------------------------------------------
  byte_t        dict_mem [DEPTH];
  logic [12:0]  wr_pos = 13'd1;
  logic [12:0]  cp_pos = '0;
  parse_phase_t phase_q = PH_FLAG;
  int           bits_todo = 0;
  logic [15:0]  field_acc = '0;
  bit           stream_done = 1'b0;
  out_item_t    run_items[$];
  out_item_t    pending_output[$];

  in_item_t     compressed_q[$];
  bit           gen_bits[$];
  int           items_queued = 0;
  int           accepted_items = 0;
  int           mismatch_count = 0;
  gap_mode_t    gap_mode = GAP_NONE;
  bit           hold_req = 1'b0;
  int           hold_left = 0;
  in_item_t     next_in;
  out_item_t    want_item;

  initial begin
    foreach (dict_mem[i]) dict_mem[i] = '0;
  end

  // Every decoded byte lands in the dictionary; only the first 18 of a run are reported.
  function automatic void store_byte(byte_t b);
    dict_mem[wr_pos] = b;
    wr_pos = wr_pos + 13'd1;
    if (run_items.size() < MAX_OUT - 1) run_items.push_back('{b, 1'b1, 1'b0, 1'b0});
  endfunction

  function automatic void decode_bit(bit b);
    int n;
    if (phase_q == PH_FLAG) begin
      phase_q   = b ? PH_LITERAL : PH_POSITION;
      bits_todo = b ? BYTE_W : POS_W;
      field_acc = '0;
      return;
    end
    field_acc = {field_acc[14:0], b};
    if (bits_todo > 0) bits_todo--;
    if (bits_todo != 0) return;
    case (phase_q)
      PH_LITERAL: begin
        store_byte(field_acc[7:0]);
        phase_q = PH_FLAG;
      end
      PH_POSITION: begin
        if (field_acc == 16'd0) begin
          // zero position is the end marker
          stream_done = 1'b1;
          run_items.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
          phase_q = PH_FLAG;
        end else begin
          cp_pos    = field_acc[12:0];
          phase_q   = PH_LENGTH;
          bits_todo = LEN_W;
        end
      end
      default: begin
        n = int'(field_acc) + COPY_BIAS;
        for (int i = 0; i < n; i++) begin
          store_byte(dict_mem[cp_pos]);
          cp_pos = cp_pos + 13'd1;
        end
        phase_q = PH_FLAG;
      end
    endcase
    field_acc = '0;
    if (phase_q == PH_FLAG) bits_todo = 0;
  endfunction

  function automatic void predict_item(byte_t data, bit first, bit final_in);
    run_items.delete();
    if (first) begin
      wr_pos      = 13'd1;
      phase_q     = PH_FLAG;
      bits_todo   = 0;
      field_acc   = '0;
      stream_done = 1'b0;
    end
    for (int k = 7; k >= 0; k--)
      if (!stream_done) decode_bit(data[k]);
    // zero fill after a final byte until the end marker shows up
    if (final_in)
      while (!stream_done) decode_bit(1'b0);
    if (run_items.size() != 0) run_items[run_items.size() - 1].last = 1'b1;
    foreach (run_items[i]) pending_output.push_back(run_items[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stream builder: fields go into a bit list, packed MSB first into items
  // ---------------------------------------------------------------------------
  function automatic void put_field(int value, int width);
    for (int i = width - 1; i >= 0; i--) gen_bits.push_back(value[i]);
  endfunction

  function automatic void queue_item(byte_t d, bit first, bit final_in);
    compressed_q.push_back('{d, first, final_in});
    items_queued++;
  endfunction

  function automatic void emit_stream(bit mark_final, bit pad_rand);
    int    nbytes;
    byte_t b;
    while (gen_bits.size() % 8 != 0)
      gen_bits.push_back(pad_rand ? ($urandom_range(1) != 0) : 1'b0);
    nbytes = gen_bits.size() / 8;
    for (int i = 0; i < nbytes; i++) begin
      for (int k = 7; k >= 0; k--) b[k] = gen_bits.pop_front();
      queue_item(b, i == 0, mark_final && (i == nbytes - 1));
    end
  endfunction

  // Mostly well-formed streams; copies lean on positions already written.
  task automatic gen_random_stream();
    int n_tok;
    int produced;
    int pos;
    int len;
    int kind;
    n_tok    = $urandom_range(6, 1);
    produced = 0;
    repeat (n_tok) begin
      if ($urandom_range(1) != 0) begin
        put_field(1, 1);
        put_field($urandom_range(255), BYTE_W);
        produced++;
      end else begin
        if (produced > 0 && $urandom_range(3) != 0) pos = $urandom_range(produced, 1);
        else pos = $urandom_range(DEPTH - 1, 1);
        len = $urandom_range((1 << LEN_W) - 1);
        put_field(0, 1);
        put_field(pos, POS_W);
        put_field(len, LEN_W);
        produced += len + COPY_BIAS;
      end
    end
    kind = $urandom_range(9);
    if (kind < 6) begin
      put_field(0, 1 + POS_W);                  // explicit end marker
      emit_stream($urandom_range(1) != 0, 1'b1);
    end else if (kind < 9) begin
      emit_stream(1'b1, $urandom_range(1) != 0); // ends by zero fill
    end else begin
      emit_stream(1'b0, 1'b1);                   // abandoned, next stream restarts
    end
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(3, 1))
      queue_item(byte_t'($urandom_range(255)), $urandom_range(1) != 0,
                 $urandom_range(1) != 0);
  endtask

  task automatic gen_directed();
    // literal extremes, shortest and longest copy, farthest position, end marker
    put_field(1, 1); put_field(8'h00, BYTE_W);
    put_field(1, 1); put_field(8'hFF, BYTE_W);
    put_field(0, 1); put_field(1, POS_W); put_field(0, LEN_W);
    put_field(0, 1); put_field(DEPTH - 1, POS_W); put_field((1 << LEN_W) - 1, LEN_W);
    put_field(0, 1 + POS_W);
    emit_stream(1'b0, 1'b1);
    // items after the end marker are dropped, a final one too
    queue_item(8'hC3, 1'b0, 1'b0);
    queue_item(8'h81, 1'b0, 1'b1);
    // final byte finishes an 18-byte copy, zero fill adds another copy: output capped
    put_field(1, 1); put_field(8'h5A, BYTE_W);
    put_field(0, 1); put_field(1, POS_W); put_field((1 << LEN_W) - 1, LEN_W);
    put_field(1, 2);
    emit_stream(1'b1, 1'b0);
    // partial literal, then a restart mid-stream
    queue_item(8'hA5, 1'b1, 1'b0);
    put_field(1, 1); put_field(8'h3C, BYTE_W);
    emit_stream(1'b1, 1'b0);
    // zero fill completes a half-received position and the length field
    put_field(1, 1); put_field(8'h41, BYTE_W);
    put_field(0, 1); put_field(1, 6);
    emit_stream(1'b1, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Idling and pressure
  // ---------------------------------------------------------------------------
  function automatic bit send_gap();
    int r;
    r = $urandom_range(99);
    return (gap_mode == GAP_SENDER && r < 84) || (gap_mode == GAP_BOTH && r < 20);
  endfunction

  function automatic bit recv_gap();
    int r;
    r = $urandom_range(99);
    return (gap_mode == GAP_RECEIVER && r < 84) || (gap_mode == GAP_BOTH && r < 20);
  endfunction

  // long receiver hold-off, counted here so the sender keeps offering meanwhile
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers compressed items, predicts on each accepted one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predict_item(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
        accepted_items++;
      end
      if (compressed_q.size() != 0 && !send_gap()) begin
        next_in = compressed_q.pop_front();
        s_axis_tdata  <= next_in.data;
        s_axis_tuser  <= next_in.first;
        s_axis_tlast  <= next_in.final_in;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each output item with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_output.size() == 0) begin
          report_mismatch($sformatf("output item with none predicted, data %02h user %b",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want_item = pending_output.pop_front();
          if (m_axis_tdata !== want_item.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata, want_item.data));
          if (m_axis_tuser[0] !== want_item.valid)
            report_mismatch($sformatf("byte_valid %b, want %b", m_axis_tuser[0], want_item.valid));
          if (m_axis_tuser[1] !== want_item.done)
            report_mismatch($sformatf("stream_end %b, want %b", m_axis_tuser[1], want_item.done));
          if (m_axis_tlast !== want_item.last)
            report_mismatch($sformatf("last_of_run %b, want %b", m_axis_tlast, want_item.last));
        end
      end
      m_axis_tready <= (hold_left == 0) && !recv_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, then one stimulus phase per idling mode
  // ---------------------------------------------------------------------------
  initial begin
    gap_mode_t phase_modes[4];
    int        target;
    phase_modes = '{GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (phase_modes[p]) begin
      gap_mode = phase_modes[p];
      if (p == 0) gen_directed();
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) begin
        if ($urandom_range(99) < 85) gen_random_stream();
        else gen_noise();
      end
      if (p == 0) begin
        // the dictionary clear keeps input closed; hold off once data flows
        while (accepted_items == 0) @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      while (compressed_q.size() != 0 || s_axis_tvalid || pending_output.size() != 0)
        @(posedge clk);
    end
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_output.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
